// ----- design/u8v_pkg.sv -----
package u8v_pkg;

  // Lead byte class boundaries
  localparam logic [7:0] LEAD_MULTI_MIN = 8'h80;
  localparam logic [7:0] LEAD_2B_MIN    = 8'hC2;
  localparam logic [7:0] LEAD_3B_MIN    = 8'hE0;
  localparam logic [7:0] LEAD_4B_MIN    = 8'hF0;
  localparam logic [7:0] LEAD_5B_MIN    = 8'hF8;
  localparam logic [7:0] LEAD_6B_MIN    = 8'hFC;
  localparam logic [7:0] LEAD_BAD_MIN   = 8'hFE;

  // Continuation bytes are 10xx_xxxx
  localparam logic [1:0] CONT_TAG       = 2'b10;

  // Lower bounds on the second byte, against overlong forms
  localparam logic [7:0] SECOND_MIN_ANY = 8'h80;
  localparam logic [7:0] SECOND_MIN_E0  = 8'hA0;
  localparam logic [7:0] SECOND_MIN_F0  = 8'h90;
  localparam logic [7:0] SECOND_MIN_F8  = 8'h88;
  localparam logic [7:0] SECOND_MIN_FC  = 8'h84;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       ends_char;
    logic       bad_so_far;
    logic       string_done;
    logic       string_valid;
  } out_item_t;

  typedef struct packed {
    logic [2:0] bytes_pending;
    logic [7:0] second_byte_min;
    logic       expect_second;
    logic       error_seen;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    bytes_pending:   3'd0,
    second_byte_min: SECOND_MIN_ANY,
    expect_second:   1'b0,
    error_seen:      1'b0
  };

endpackage

// ----- design/u8v_decode.sv -----
module u8v_decode
  import u8v_pkg::*;
(
  input  dec_state_t state_cur,
  input  in_item_t   item,
  output dec_state_t state_nxt,
  output out_item_t  result
);

  logic [7:0] b;
  logic       bad;
  logic       done_char;
  logic       cont;
  logic       err;
  dec_state_t st_step;

  assign b = item.data_byte;

  always_comb begin
    st_step   = state_cur;
    bad       = 1'b0;
    done_char = 1'b0;
    cont      = 1'b0;
    if (state_cur.bytes_pending == 3'd0) begin
      // Decode a lead byte
      if (b < LEAD_MULTI_MIN) begin
        done_char = 1'b1;
      end else if (b < LEAD_2B_MIN) begin
        bad = 1'b1;
      end else if (b < LEAD_3B_MIN) begin
        st_step.bytes_pending   = 3'd1;
        st_step.second_byte_min = SECOND_MIN_ANY;
        st_step.expect_second   = 1'b1;
      end else if (b < LEAD_4B_MIN) begin
        st_step.bytes_pending   = 3'd2;
        st_step.second_byte_min = (b == LEAD_3B_MIN) ? SECOND_MIN_E0 : SECOND_MIN_ANY;
        st_step.expect_second   = 1'b1;
      end else if (b < LEAD_5B_MIN) begin
        st_step.bytes_pending   = 3'd3;
        st_step.second_byte_min = (b == LEAD_4B_MIN) ? SECOND_MIN_F0 : SECOND_MIN_ANY;
        st_step.expect_second   = 1'b1;
      end else if (b < LEAD_6B_MIN) begin
        st_step.bytes_pending   = 3'd4;
        st_step.second_byte_min = (b == LEAD_5B_MIN) ? SECOND_MIN_F8 : SECOND_MIN_ANY;
        st_step.expect_second   = 1'b1;
      end else if (b < LEAD_BAD_MIN) begin
        st_step.bytes_pending   = 3'd5;
        st_step.second_byte_min = (b == LEAD_6B_MIN) ? SECOND_MIN_FC : SECOND_MIN_ANY;
        st_step.expect_second   = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end else begin
      // Check a continuation byte, with the overlong bound on the second one
      cont = (b[7:6] == CONT_TAG);
      if (cont && state_cur.expect_second && (b < state_cur.second_byte_min)) begin
        cont = 1'b0;
      end
      if (!cont) begin
        bad = 1'b1;
      end else begin
        st_step.bytes_pending = state_cur.bytes_pending - 3'd1;
        st_step.expect_second = 1'b0;
        if (st_step.bytes_pending == 3'd0) begin
          done_char = 1'b1;
        end
      end
    end

    // Drop the sequence in progress on any error
    if (bad) begin
      st_step.bytes_pending   = 3'd0;
      st_step.expect_second   = 1'b0;
      st_step.second_byte_min = SECOND_MIN_ANY;
    end

    err = state_cur.error_seen || bad ||
          (item.last_of_string && (st_step.bytes_pending != 3'd0));

    result.byte_out     = b;
    result.ends_char    = done_char && !bad && !state_cur.error_seen;
    result.bad_so_far   = err;
    result.string_done  = item.last_of_string;
    result.string_valid = item.last_of_string && !err;

    if (item.last_of_string) begin
      state_nxt = STATE_RESET;
    end else begin
      state_nxt            = st_step;
      state_nxt.error_seen = err;
    end
  end

endmodule

// ----- design/utf8_sequence_validator.sv -----
// UTF-8 sequence validator, legacy scheme with sequences of up to six bytes.
// Input channel (in_valid / in_stall / in_data) takes one request per byte of
// a string; in_data.last_of_string marks the final byte of each string.
// Result channel (out_valid / out_stall / out_data) gives exactly one request
// per input byte, in order: the byte itself, whether it completes a valid
// character, the sticky error flag and, on the final byte, string_valid.
// Path: a byte accepted by the input register moves on to the result register
// and from there to out_data, waiting in place while the receiver stalls.
// Throughput: one byte per cycle, sustained, while the receiver does not stall.
// The per-byte decision is a handful of compares in one combinational step
// between the input register and the result register; the decoder state
// advances in the same cycle that a byte moves into the result register.
// When the receiver stalls, the result register holds, the input register
// keeps its byte and the block stalls the sender once that register is full.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to the start of a string. No clearing pass is needed.
module utf8_sequence_validator
  import u8v_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  out_item_t  result;
  logic       out_free;
  logic       advance;
  logic       in_take;

  // Result register is free when empty or being taken this cycle
  assign out_free = !out_vld_r || !out_stall;
  // Advance the held byte into the result register
  assign advance  = in_vld_r && out_free;
  // Input register can accept when empty or emptying this cycle
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  u8v_decode u_decode (
    .state_cur (st_r),
    .item      (in_item_r),
    .state_nxt (st_nxt),
    .result    (result)
  );

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  // Input register payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // Decoder state moves on only with the byte it belongs to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

`ifndef SYNTHESIS
  // A final byte returns the decoder to the start of a string
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_item_r.last_of_string |=>
      (st_r.bytes_pending == 3'd0) && !st_r.error_seen && !st_r.expect_second)
    else $error("decoder state not cleared after final byte");

  // Second-byte flag only while a sequence is open
  a_second_open: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.expect_second |-> (st_r.bytes_pending != 3'd0))
    else $error("expect_second set with no bytes pending");

  // A completed character never coexists with an error
  a_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.ends_char |-> !out_item_r.bad_so_far)
    else $error("ends_char reported together with an error");

  // string_valid only on a final, error-free byte
  a_valid_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.string_valid |->
      out_item_r.string_done && !out_item_r.bad_so_far)
    else $error("string_valid on a non-final or faulty byte");

  // A held byte is not lost while the result side stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && out_stall |=> in_vld_r && $stable(in_item_r))
    else $error("input register lost its byte under stall");
`endif

endmodule
